### design/c8_pkg.sv
// shared constants, types and helper functions for the chip8 instruction step unit
// no dependencies
package c8_pkg;

  localparam int MEM_BYTES      = 4096;
  localparam int AW             = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH    = 16;
  localparam int SIW            = $clog2(STACK_DEPTH);
  localparam int SPW            = $clog2(STACK_DEPTH + 1);
  localparam int DISP_W         = 64;
  localparam int DISP_H         = 32;
  localparam int DAW            = $clog2(DISP_H);
  localparam int DXW            = $clog2(DISP_W);
  localparam int FONT_BYTES     = 80;

  localparam logic [AW-1:0] PROG_START = AW'(12'h200);
  localparam logic [15:0]   OPC_CLS    = 16'h00E0;
  localparam logic [15:0]   OPC_RET    = 16'h00EE;

  typedef enum logic [1:0] {
    OP_EXEC = 2'd0,
    OP_LOAD = 2'd1,
    OP_ROW  = 2'd2,
    OP_REG  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_REFUSED   = 3'd3,
    ST_KEY_WAIT  = 3'd4
  } status_t;

  // main memory request: one write port and one read port per cycle
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  // display memory request
  typedef struct packed {
    logic              we;
    logic              clr;
    logic [DAW-1:0]    waddr;
    logic [DISP_W-1:0] wdata;
    logic [DAW-1:0]    raddr;
  } disp_req_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] b;
    unique case (idx)
      7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25, 7'd27,
      7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45, 7'd47, 7'd49,
      7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75, 7'd77: b = 8'hF0;
      7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51, 7'd53,
      7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: b = 8'h90;
      7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
      7'd6: b = 8'h60;
      7'd9: b = 8'h70;
      7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
      7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
      7'd79: b = 8'h80;
      7'd38, 7'd39: b = 8'h40;
      7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // hundreds, tens, units of an 8-bit value
  function automatic logic [11:0] bcd8(input logic [7:0] v);
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] t;
    logic [7:0] u;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - 8'(h * 100);
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(k * 10)) t = 4'(k);
    end
    u = r - 8'(t * 10);
    return {2'b00, h, t, u[3:0]};
  endfunction

  function automatic logic [3:0] first_key(input logic [15:0] keys);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys[i]) k = 4'(i);
    end
    return k;
  endfunction

endpackage

### design/chip8_instruction_step_unit.sv
// top level of the chip8 instruction step unit: sequencer, register file, return stack
// instantiates c8_main_mem and c8_disp_mem; uses c8_pkg
//
//  channel   direction  ports                                               handshake
//  in_       input      op, addr, data, key_mask, random_byte              in_valid / in_stall
//  out_      output     pc_out, index_out, read_data, status, collision,   out_valid / out_stall
//                       sound_out
//
// after reset a clearing pass loads the font and zeroes main memory;
//   in_stall stays high until it ends
// one transaction at a time: load and register read pass through S_DONE, row read through S_ROW,
//   a plain instruction through S_F1, S_F2 and S_EXE (two main memory reads, decode and result)
// a draw adds a read state and a write state per sprite row, Fx33 one write per digit, Fx55 one
//   write per register and Fx65 a read and a write per register, set by the one main memory read and write port
// the result register lets the next transaction be accepted while out_stall holds a result
// reset is synchronous, active low
module chip8_instruction_step_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [11:0]               in_addr,
  input  logic [7:0]                in_data,
  input  logic [15:0]               in_key_mask,
  input  logic [7:0]                in_random_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [11:0]               out_pc_out,
  output logic [15:0]               out_index_out,
  output logic [63:0]               out_read_data,
  output logic [2:0]                out_status,
  output logic                      out_collision,
  output logic [7:0]                out_sound_out
);

  localparam int AW  = c8_pkg::AW;
  localparam int SPW = c8_pkg::SPW;
  localparam int SIW = c8_pkg::SIW;
  localparam int DW  = c8_pkg::DISP_W;
  localparam int DAW = c8_pkg::DAW;
  localparam int DXW = c8_pkg::DXW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ROW, S_F1, S_F2, S_EXE, S_DRD, S_DWR,
    S_BCD, S_ST, S_LDR, S_LDW, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [11:0]       addr_r, addr_nxt;
  logic [15:0]       keys_r, keys_nxt;
  logic [7:0]        rnd_r, rnd_nxt;
  logic [AW-1:0]     pc_r, pc_nxt;
  logic [15:0]       i_r, i_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [7:0]        delay_r, delay_nxt;
  logic [7:0]        sound_r, sound_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [15:0]       ir_r, ir_nxt;
  logic [7:0]        vx_r, vx_nxt;
  logic [7:0]        vy_r, vy_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              hit_r, hit_nxt;
  logic [11:0]       bcd_r, bcd_nxt;
  logic [DW-1:0]     rd_r, rd_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              coll_r, coll_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [11:0]       o_pc_r, o_pc_nxt;
  logic [15:0]       o_i_r, o_i_nxt;
  logic [63:0]       o_rd_r, o_rd_nxt;
  logic [2:0]        o_st_r, o_st_nxt;
  logic              o_coll_r, o_coll_nxt;
  logic [7:0]        o_snd_r, o_snd_nxt;

  // register file and return stack
  logic [7:0]        v_q [16];
  logic [AW-1:0]     stk_q [c8_pkg::STACK_DEPTH];
  logic [3:0]        v_ra;
  logic [7:0]        v_rd;
  logic              v_we, vf_we;
  logic [3:0]        v_wa;
  logic [7:0]        v_wd, vf_wd;
  logic              stk_we;
  logic [SIW-1:0]    stk_wa;
  logic [AW-1:0]     stk_wd;
  logic [SPW-1:0]    sp_dec;
  logic [AW-1:0]     stk_rd;

  c8_pkg::mem_req_t  mreq;
  c8_pkg::disp_req_t dreq;
  logic [7:0]        m_rdata;
  logic [DW-1:0]     d_rdata;
  logic              init_done;

  // decode fields of the held instruction
  logic [3:0]        f_hi, f_x, f_y, f_n;
  logic [7:0]        f_kk;
  logic [AW-1:0]     f_nnn;
  logic [AW-1:0]     pc_inc, pc_skip, i_lo;
  logic [8:0]        sum9;
  logic [DW-1:0]     spr_base, spr_mask;
  logic [2*DW-1:0]   spr_rot;
  logic [DW-1:0]     row_new;

  c8_main_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mreq),
    .rdata     (m_rdata),
    .init_done (init_done)
  );

  c8_disp_mem u_disp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rdata (d_rdata)
  );

  assign sp_dec = sp_r - 1'b1;
  assign stk_rd = stk_q[sp_dec[SIW-1:0]];
  assign v_rd   = v_q[v_ra];

  assign f_hi   = ir_r[15:12];
  assign f_x    = ir_r[11:8];
  assign f_y    = ir_r[7:4];
  assign f_n    = ir_r[3:0];
  assign f_kk   = ir_r[7:0];
  assign f_nnn  = ir_r[AW-1:0];
  assign pc_inc = pc_r + AW'(2);
  assign pc_skip = pc_r + AW'(4);
  assign i_lo   = i_r[AW-1:0] + AW'(cnt_r);

  // sprite byte placed msb-first at column 0, then rotated to column vx
  always_comb begin
    spr_base = '0;
    for (int c = 0; c < 8; c++) begin
      spr_base[c] = m_rdata[7-c];
    end
    spr_rot  = {spr_base, spr_base} << vx_r[DXW-1:0];
    spr_mask = spr_rot[2*DW-1:DW];
    row_new  = d_rdata ^ spr_mask;
  end

  // register file read port: one address per cycle, chosen by state
  always_comb begin
    unique case (state_r)
      S_IDLE:  v_ra = in_addr[3:0];
      S_F2:    v_ra = hi_r[3:0];
      S_EXE:   v_ra = (f_hi == 4'hB) ? 4'd0 : f_y;
      S_ST:    v_ra = cnt_r;
      default: v_ra = 4'd0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    keys_nxt   = keys_r;
    rnd_nxt    = rnd_r;
    pc_nxt     = pc_r;
    i_nxt      = i_r;
    sp_nxt     = sp_r;
    delay_nxt  = delay_r;
    sound_nxt  = sound_r;
    hi_nxt     = hi_r;
    ir_nxt     = ir_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    cnt_nxt    = cnt_r;
    hit_nxt    = hit_r;
    bcd_nxt    = bcd_r;
    rd_nxt     = rd_r;
    status_nxt = status_r;
    coll_nxt   = coll_r;
    o_pc_nxt   = o_pc_r;
    o_i_nxt    = o_i_r;
    o_rd_nxt   = o_rd_r;
    o_st_nxt   = o_st_r;
    o_coll_nxt = o_coll_r;
    o_snd_nxt  = o_snd_r;
    out_valid_nxt = out_valid_r && out_stall;
    mreq       = '0;
    dreq       = '0;
    v_we       = 1'b0;
    v_wa       = f_x;
    v_wd       = 8'h00;
    vf_we      = 1'b0;
    vf_wd      = 8'h00;
    stk_we     = 1'b0;
    stk_wa     = sp_r[SIW-1:0];
    stk_wd     = pc_inc;
    sum9       = {1'b0, vx_r} + {1'b0, v_rd};

    unique case (state_r)
      S_INIT: begin
        if (init_done) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          addr_nxt   = in_addr;
          keys_nxt   = in_key_mask;
          rnd_nxt    = in_random_byte;
          status_nxt = c8_pkg::ST_OK;
          coll_nxt   = 1'b0;
          rd_nxt     = '0;
          cnt_nxt    = 4'd0;
          hit_nxt    = 1'b0;
          unique case (c8_pkg::op_t'(in_op))
            c8_pkg::OP_EXEC: begin
              mreq.raddr = pc_r;
              state_nxt  = S_F1;
            end
            c8_pkg::OP_LOAD: begin
              if (in_addr < c8_pkg::PROG_START) begin
                status_nxt = c8_pkg::ST_REFUSED;
              end else begin
                mreq.we    = 1'b1;
                mreq.waddr = in_addr;
                mreq.wdata = in_data;
              end
              state_nxt = S_DONE;
            end
            c8_pkg::OP_ROW: begin
              dreq.raddr = in_addr[DAW-1:0];
              state_nxt  = S_ROW;
            end
            c8_pkg::OP_REG: begin
              rd_nxt    = (in_addr < 12'd16) ? {{(DW-8){1'b0}}, v_rd} : '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_ROW: begin
        rd_nxt    = (addr_r < 12'(c8_pkg::DISP_H)) ? d_rdata : '0;
        state_nxt = S_DONE;
      end

      S_F1: begin
        hi_nxt     = m_rdata;
        mreq.raddr = pc_r + AW'(1);
        state_nxt  = S_F2;
      end

      S_F2: begin
        ir_nxt    = {hi_r, m_rdata};
        vx_nxt    = v_rd;
        state_nxt = S_EXE;
      end

      S_EXE: begin
        pc_nxt    = pc_inc;
        vy_nxt    = v_rd;
        state_nxt = S_DONE;
        unique case (f_hi)
          4'h0: begin
            if (ir_r == c8_pkg::OPC_CLS) begin
              dreq.clr = 1'b1;
            end else if (ir_r == c8_pkg::OPC_RET) begin
              if (sp_r != '0) begin
                sp_nxt = sp_dec;
                pc_nxt = stk_rd;
              end else begin
                status_nxt = c8_pkg::ST_UNDERFLOW;
              end
            end
          end
          4'h1: pc_nxt = f_nnn;
          4'h2: begin
            if (sp_r < SPW'(c8_pkg::STACK_DEPTH)) begin
              stk_we = 1'b1;
              sp_nxt = sp_r + 1'b1;
              pc_nxt = f_nnn;
            end else begin
              status_nxt = c8_pkg::ST_OVERFLOW;
            end
          end
          4'h3: if (vx_r == f_kk) pc_nxt = pc_skip;
          4'h4: if (vx_r != f_kk) pc_nxt = pc_skip;
          4'h5: if (vx_r == v_rd) pc_nxt = pc_skip;
          4'h9: if (vx_r != v_rd) pc_nxt = pc_skip;
          4'h6: begin
            v_we = 1'b1;
            v_wd = f_kk;
          end
          4'h7: begin
            v_we = 1'b1;
            v_wd = vx_r + f_kk;
          end
          4'h8: begin
            unique case (f_n)
              4'h0: begin v_we = 1'b1; v_wd = v_rd; end
              4'h1: begin v_we = 1'b1; v_wd = vx_r | v_rd; end
              4'h2: begin v_we = 1'b1; v_wd = vx_r & v_rd; end
              4'h3: begin v_we = 1'b1; v_wd = vx_r ^ v_rd; end
              4'h4: begin
                v_we = 1'b1; v_wd = sum9[7:0];
                vf_we = 1'b1; vf_wd = {7'd0, sum9[8]};
              end
              4'h5: begin
                v_we = 1'b1; v_wd = vx_r - v_rd;
                vf_we = 1'b1; vf_wd = {7'd0, vx_r > v_rd};
              end
              4'h6: begin
                v_we = 1'b1; v_wd = {1'b0, vx_r[7:1]};
                vf_we = 1'b1; vf_wd = {7'd0, vx_r[0]};
              end
              4'h7: begin
                v_we = 1'b1; v_wd = v_rd - vx_r;
                vf_we = 1'b1; vf_wd = {7'd0, v_rd > vx_r};
              end
              4'hE: begin
                v_we = 1'b1; v_wd = {vx_r[6:0], 1'b0};
                vf_we = 1'b1; vf_wd = {7'd0, vx_r[7]};
              end
              default: ;
            endcase
          end
          4'hA: i_nxt = {{(16-AW){1'b0}}, f_nnn};
          4'hB: pc_nxt = f_nnn + AW'(v_rd);
          4'hC: begin
            v_we = 1'b1;
            v_wd = rnd_r & f_kk;
          end
          4'hD: begin
            // zero-row sprite: nothing drawn, flag cleared
            if (f_n == 4'd0) begin
              vf_we = 1'b1;
              vf_wd = 8'h00;
            end else begin
              state_nxt = S_DRD;
            end
          end
          4'hE: begin
            if (f_kk == 8'h9E && keys_r[vx_r[3:0]]) pc_nxt = pc_skip;
            else if (f_kk == 8'hA1 && !keys_r[vx_r[3:0]]) pc_nxt = pc_skip;
          end
          4'hF: begin
            unique case (f_kk)
              8'h07: begin v_we = 1'b1; v_wd = delay_r; end
              8'h0A: begin
                if (keys_r == 16'h0000) begin
                  pc_nxt     = pc_r;
                  status_nxt = c8_pkg::ST_KEY_WAIT;
                end else begin
                  v_we = 1'b1;
                  v_wd = {4'd0, c8_pkg::first_key(keys_r)};
                end
              end
              8'h15: delay_nxt = vx_r;
              8'h18: sound_nxt = vx_r;
              8'h1E: i_nxt = i_r + {8'd0, vx_r};
              8'h29: i_nxt = {6'd0, vx_r, 2'b00} + {8'd0, vx_r};
              8'h33: begin
                bcd_nxt   = c8_pkg::bcd8(vx_r);
                state_nxt = S_BCD;
              end
              8'h55: state_nxt = S_ST;
              8'h65: state_nxt = S_LDR;
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      // sprite row: fetch byte and display row together, then merge and write back
      S_DRD: begin
        mreq.raddr = i_lo;
        dreq.raddr = vy_r[DAW-1:0] + DAW'(cnt_r);
        state_nxt  = S_DWR;
      end

      S_DWR: begin
        dreq.we    = 1'b1;
        dreq.waddr = vy_r[DAW-1:0] + DAW'(cnt_r);
        dreq.wdata = row_new;
        hit_nxt    = hit_r | (|(d_rdata & spr_mask));
        if (cnt_r == f_n - 4'd1) begin
          vf_we     = 1'b1;
          vf_wd     = {7'd0, hit_nxt};
          coll_nxt  = hit_nxt;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_DRD;
        end
      end

      S_BCD: begin
        mreq.we    = 1'b1;
        mreq.waddr = i_lo;
        unique case (cnt_r[1:0])
          2'd0:    mreq.wdata = {4'd0, bcd_r[11:8]};
          2'd1:    mreq.wdata = {4'd0, bcd_r[7:4]};
          default: mreq.wdata = {4'd0, bcd_r[3:0]};
        endcase
        if (cnt_r == 4'd2) state_nxt = S_DONE;
        else cnt_nxt = cnt_r + 4'd1;
      end

      S_ST: begin
        mreq.we    = 1'b1;
        mreq.waddr = i_lo;
        mreq.wdata = v_rd;
        if (cnt_r == f_x) state_nxt = S_DONE;
        else cnt_nxt = cnt_r + 4'd1;
      end

      S_LDR: begin
        mreq.raddr = i_lo;
        state_nxt  = S_LDW;
      end

      S_LDW: begin
        v_we = 1'b1;
        v_wa = cnt_r;
        v_wd = m_rdata;
        if (cnt_r == f_x) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_LDR;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_pc_nxt      = pc_r;
          o_i_nxt       = i_r;
          o_rd_nxt      = rd_r;
          o_st_nxt      = status_r;
          o_coll_nxt    = coll_r;
          o_snd_nxt     = sound_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pc_r        <= c8_pkg::PROG_START;
      i_r         <= '0;
      sp_r        <= '0;
      delay_r     <= '0;
      sound_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sp_r        <= sp_nxt;
      delay_r     <= delay_nxt;
      sound_r     <= sound_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r   <= addr_nxt;
    keys_r   <= keys_nxt;
    rnd_r    <= rnd_nxt;
    hi_r     <= hi_nxt;
    ir_r     <= ir_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    cnt_r    <= cnt_nxt;
    hit_r    <= hit_nxt;
    bcd_r    <= bcd_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
    coll_r   <= coll_nxt;
    o_pc_r   <= o_pc_nxt;
    o_i_r    <= o_i_nxt;
    o_rd_r   <= o_rd_nxt;
    o_st_r   <= o_st_nxt;
    o_coll_r <= o_coll_nxt;
    o_snd_r  <= o_snd_nxt;
  end

  // register file: vf written after vx so the flag wins when x is 15
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) v_q[k] <= 8'h00;
    end else begin
      if (v_we) v_q[v_wa] <= v_wd;
      if (vf_we) v_q[15] <= vf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < c8_pkg::STACK_DEPTH; k++) stk_q[k] <= '0;
    end else if (stk_we) begin
      stk_q[stk_wa] <= stk_wd;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pc_out    = o_pc_r;
  assign out_index_out = o_i_r;
  assign out_read_data = o_rd_r;
  assign out_status    = o_st_r;
  assign out_collision = o_coll_r;
  assign out_sound_out = o_snd_r;

  // stack pointer never runs past the stack
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(c8_pkg::STACK_DEPTH))
    else $error("stack pointer out of range");

  // no transaction is taken before the clearing pass ends
  a_init_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> init_done)
    else $error("transaction accepted during clearing pass");

  // sprite row counter stays below the sprite height
  a_draw_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWR) |-> (cnt_r < f_n))
    else $error("draw row counter overran");

  // a collision is only reported for a draw instruction
  a_coll_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && coll_r) |-> (f_hi == 4'hD))
    else $error("collision without draw");

  // status codes stay within the defined set
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'd4))
    else $error("undefined status code");

endmodule

### design/c8_main_mem.sv
// 4096 x 8 main memory with registered read and a clearing pass after reset
// the pass loads the font glyphs and zeroes the rest; uses c8_pkg
module c8_main_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  c8_pkg::mem_req_t     req,
  output logic [7:0]           rdata,
  output logic                 init_done
);

  logic [7:0]            mem [c8_pkg::MEM_BYTES];
  logic [c8_pkg::AW-1:0] init_cnt_r, init_cnt_nxt;
  logic                  init_done_r, init_done_nxt;
  logic [7:0]            rdata_r;
  logic [7:0]            init_val;

  always_comb begin
    init_val      = (init_cnt_r < c8_pkg::AW'(c8_pkg::FONT_BYTES)) ?
                    c8_pkg::font_byte(init_cnt_r[6:0]) : 8'h00;
    init_cnt_nxt  = init_cnt_r;
    init_done_nxt = init_done_r;
    if (!init_done_r) begin
      init_cnt_nxt = init_cnt_r + 1'b1;
      if (init_cnt_r == {c8_pkg::AW{1'b1}}) init_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      init_done_r <= 1'b0;
    end else begin
      init_cnt_r  <= init_cnt_nxt;
      init_done_r <= init_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done_r) begin
      mem[init_cnt_r] <= init_val;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata     = rdata_r;
  assign init_done = init_done_r;

endmodule

### design/c8_disp_mem.sv
// 32 x 64 display row memory with registered read and per-row valid bits
// a row that is not valid reads as blank; uses c8_pkg
module c8_disp_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  c8_pkg::disp_req_t         req,
  output logic [c8_pkg::DISP_W-1:0] rdata
);

  logic [c8_pkg::DISP_W-1:0] mem [c8_pkg::DISP_H];
  logic [c8_pkg::DISP_H-1:0] valid_r, valid_nxt;
  logic [c8_pkg::DISP_W-1:0] rdata_r;
  logic                      rvalid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (req.clr) begin
      valid_nxt = '0;
    end else if (req.we) begin
      valid_nxt[req.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r  <= mem[req.raddr];
    rvalid_r <= valid_r[req.raddr];
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule
